// ===== rtl/cau_pkg.sv =====
// cau_pkg: widths, operation and status codes, divider and square-root unit sizes,
// and the rounding and saturation helpers of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int OP_W = 3;
    localparam int STAT_W = 2;
    localparam int IN_DATA_W = 4 * DATA_W;
    localparam int OUT_DATA_W = 2 * DATA_W;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_CONJ = 3'd4;
    localparam logic [OP_W-1:0] OP_ABS = 3'd5;
    localparam logic [OP_W-1:0] OP_SQRT = 3'd6;
    localparam logic [OP_W-1:0] OP_SCALE = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK = 2'd0;
    localparam logic [STAT_W-1:0] ST_DIVZ = 2'd1;
    localparam logic [STAT_W-1:0] ST_SAT = 2'd2;

    // divider: dividend, divisor and quotient widths
    localparam int DIV_NW = 50;
    localparam int DIV_DW = 34;
    localparam int DIV_QW = 33;
    localparam int DIV_LAT = DIV_QW + 1;

    // square root: radicand width and root bits
    localparam int SQ_IW = 64;
    localparam int SQ_HW = SQ_IW / 2;
    localparam int SQ_RW = SQ_HW + 1;
    localparam int SQ_LAT = SQ_HW + 2;

    localparam int WIDE_W = 66;
    typedef logic signed [WIDE_W-1:0] wide_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic sat;
    } sat_t;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam wide_t WIDE_HI = wide_t'(DATA_MAX);
    localparam wide_t WIDE_LO = wide_t'(DATA_MIN);

    function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // drop the fraction of a double-precision product, ties away from zero
    function automatic wide_t round_q(input wide_t v);
        logic [WIDE_W-1:0] m;
        logic [WIDE_W-1:0] r;
        m = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
        r = (m + (WIDE_W'(1) << (FRAC_W - 1))) >> FRAC_W;
        return v[WIDE_W-1] ? -wide_t'(r) : wide_t'(r);
    endfunction

    function automatic sat_t saturate(input wide_t v);
        sat_t s;
        if (v > WIDE_HI)
        begin
            s.val = DATA_MAX;
            s.sat = 1'b1;
        end
        else if (v < WIDE_LO)
        begin
            s.val = DATA_MIN;
            s.sat = 1'b1;
        end
        else
        begin
            s.val = v[DATA_W-1:0];
            s.sat = 1'b0;
        end
        return s;
    endfunction

    // signed quotient from the divider, overflow forced out of range
    function automatic wide_t to_wide(input logic [DIV_QW-1:0] q, input logic ovf,
                                      input logic neg);
        logic [WIDE_W-1:0] m;
        m = ovf ? (WIDE_W'(1) << (DATA_W + 2)) : WIDE_W'(q);
        return neg ? -wide_t'(m) : wide_t'(m);
    endfunction

endpackage

// ===== rtl/cau_div.sv =====
// cau_div: pipelined restoring divider, one quotient bit per stage, rounded to nearest.
// Depends on cau_pkg.
module cau_div (
    input  logic                      clk,
    input  logic                      ce,
    input  logic [cau_pkg::DIV_NW-1:0] num,
    input  logic [cau_pkg::DIV_DW-1:0] den,
    output logic [cau_pkg::DIV_QW-1:0] quo,
    output logic                      ovf
);
    import cau_pkg::*;

    localparam int CW = DIV_DW + DIV_QW;

    logic [DIV_NW-1:0] rem_reg [0:DIV_QW];
    logic [DIV_DW-1:0] den_reg [0:DIV_QW];
    logic [DIV_QW-1:0] q_reg [0:DIV_QW];
    logic [DIV_QW:0] ovf_reg;

    logic [DIV_NW-1:0] start;
    logic [CW-1:0] trial [1:DIV_QW];
    logic [DIV_QW:1] take;

    assign start = num + DIV_NW'(den >> 1);

    always_comb
    begin
        for (int k = 1; k <= DIV_QW; k++)
        begin
            trial[k] = CW'(den_reg[k-1]) << (DIV_QW - k);
            take[k] = CW'(rem_reg[k-1]) >= trial[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= start;
            den_reg[0] <= den;
            q_reg[0] <= '0;
            ovf_reg[0] <= CW'(start) >= (CW'(den) << DIV_QW);
            for (int k = 1; k <= DIV_QW; k++)
            begin
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                if (take[k])
                begin
                    rem_reg[k] <= DIV_NW'(CW'(rem_reg[k-1]) - trial[k]);
                    q_reg[k] <= q_reg[k-1] | (DIV_QW'(1) << (DIV_QW - k));
                end
                else
                begin
                    rem_reg[k] <= rem_reg[k-1];
                    q_reg[k] <= q_reg[k-1];
                end
            end
        end
    end

    assign quo = q_reg[DIV_QW];
    assign ovf = ovf_reg[DIV_QW];

endmodule

// ===== rtl/cau_sqrt.sv =====
// cau_sqrt: pipelined integer square root, one root bit per stage, rounded to nearest.
// Depends on cau_pkg.
module cau_sqrt (
    input  logic                     clk,
    input  logic                     ce,
    input  logic [cau_pkg::SQ_IW-1:0] rad,
    output logic [cau_pkg::SQ_RW-1:0] root
);
    import cau_pkg::*;

    localparam int TW = SQ_IW + 2;

    logic [SQ_IW-1:0] rem_reg [0:SQ_HW];
    logic [SQ_HW-1:0] rt_reg [0:SQ_HW];
    logic [SQ_RW-1:0] root_reg;

    logic [TW-1:0] trial [1:SQ_HW];
    logic [SQ_HW:1] take;

    always_comb
    begin
        for (int k = 1; k <= SQ_HW; k++)
        begin
            trial[k] = (TW'(rt_reg[k-1]) << (SQ_HW - k + 1)) |
                       (TW'(1) << (2 * (SQ_HW - k)));
            take[k] = TW'(rem_reg[k-1]) >= trial[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            rem_reg[0] <= rad;
            rt_reg[0] <= '0;
            for (int k = 1; k <= SQ_HW; k++)
            begin
                if (take[k])
                begin
                    rem_reg[k] <= SQ_IW'(TW'(rem_reg[k-1]) - trial[k]);
                    rt_reg[k] <= rt_reg[k-1] | (SQ_HW'(1) << (SQ_HW - k));
                end
                else
                begin
                    rem_reg[k] <= rem_reg[k-1];
                    rt_reg[k] <= rt_reg[k-1];
                end
            end
            root_reg <= SQ_RW'(rt_reg[SQ_HW]) +
                        SQ_RW'(rem_reg[SQ_HW] > SQ_IW'(rt_reg[SQ_HW]));
        end
    end

    assign root = root_reg;

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// complex_arithmetic_unit: pipelined complex alu in signed q16.16
// depends on cau_pkg, cau_div and cau_sqrt
//
//  channel   dir  tdata                               tuser
//  s_axis    in   a_re, a_im, b_re, b_im (32 each)    opcode (3)
//  m_axis    out  res_re, res_im (32 each)            status (2)
//
// one request per cycle unless a full output register is not taken; the pipeline depth is
// set by the squaring stage, two square roots, the square-root path divider and output
// reset clears only the valid bits of the pipeline and the output register
// a full output register that is not taken holds every stage; nothing moves or drops
module complex_arithmetic_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [cau_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  logic [cau_pkg::OP_W-1:0]       s_axis_tuser,  // opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [cau_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // res_re, res_im
    output logic [cau_pkg::STAT_W-1:0]     m_axis_tuser   // status
);
    import cau_pkg::*;

    localparam int S_R = DIV_LAT;
    localparam int S_DEN = S_R + 3;
    localparam int S_DQ = S_DEN + DIV_LAT;
    localparam int S_MG = 1 + SQ_LAT;
    localparam int S_W = S_MG + SQ_LAT;
    localparam int S_LAST = S_W + DIV_LAT;
    localparam int S_MUL = S_LAST - 2;
    localparam int RW = FRAC_W + 2;
    localparam int PW = RW + DATA_W;
    localparam int NW = DATA_W + 2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic signed [DATA_W-1:0] ar;
        logic signed [DATA_W-1:0] ai;
        logic signed [DATA_W-1:0] br;
        logic signed [DATA_W-1:0] bi;
        logic [SQ_RW-1:0] mg;
        logic [SQ_RW-1:0] w;
        logic dsre;
        logic dsim;
        logic dz;
        logic signed [DATA_W-1:0] dre;
        logic signed [DATA_W-1:0] dim;
        logic dsat;
    } pipe_t;

    pipe_t pipe_reg [0:S_LAST];
    pipe_t pipe_next [0:S_LAST];
    logic [S_LAST:0] vld_reg;
    logic out_vld_reg;
    logic ce;

    logic [DIV_QW-1:0] div1_quo, div2_quo, div3_quo, div4_quo;
    logic div1_ovf, div2_ovf, div3_ovf, div4_ovf;
    logic [SQ_RW-1:0] sq1_root, sq2_root;

    logic [2*DATA_W-1:0] xx_reg, yy_reg, xx_next, yy_next;
    logic signed [PW-1:0] pd_reg, pr_reg, pi_reg, pd_next, pr_next, pi_next;
    logic signed [NW-1:0] rd_reg, rr_reg, ri_reg, rd_next, rr_next, ri_next;
    logic signed [NW-1:0] den_reg, nr_reg, ni_reg, den_next, nr_next, ni_next;
    logic signed [2*DATA_W-1:0] mrr_reg, mii_reg, mri_reg, mir_reg;
    logic signed [2*DATA_W-1:0] mrr_next, mii_next, mri_next, mir_next;
    wide_t mre_reg, mim_reg, mre_next, mim_next;

    logic signed [DATA_W-1:0] res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic swap0, swap34, swap36;
    logic signed [DATA_W-1:0] n0, d0;
    logic signed [RW-1:0] r;
    logic [NW-1:0] nr_mag, ni_mag, den_mag;
    logic [NW-1:0] sq2_sum;
    sat_t dq_re, dq_im;

    assign ce = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = ce;

    // chain divider: r = smaller over larger part of b
    assign swap0 = mag(pipe_reg[0].br) < mag(pipe_reg[0].bi);
    assign n0 = swap0 ? pipe_reg[0].br : pipe_reg[0].bi;
    assign d0 = swap0 ? pipe_reg[0].bi : pipe_reg[0].br;

    cau_div u_div_r (
        .clk (clk),
        .ce  (ce),
        .num (DIV_NW'({mag(n0), {FRAC_W{1'b0}}})),
        .den (DIV_DW'(mag(d0))),
        .quo (div1_quo),
        .ovf (div1_ovf)
    );

    assign swap34 = mag(pipe_reg[S_R].br) < mag(pipe_reg[S_R].bi);
    always_comb
    begin
        logic neg;
        neg = swap34 ? (pipe_reg[S_R].br[DATA_W-1] ^ pipe_reg[S_R].bi[DATA_W-1])
                     : (pipe_reg[S_R].bi[DATA_W-1] ^ pipe_reg[S_R].br[DATA_W-1]);
        r = neg ? -RW'(div1_quo[RW-2:0]) : RW'(div1_quo[RW-2:0]);
        if (div1_ovf)
        begin
            r = '0;
        end
    end

    assign pd_next = PW'(r) * PW'(swap34 ? pipe_reg[S_R].br : pipe_reg[S_R].bi);
    assign pr_next = PW'(r) * PW'(pipe_reg[S_R].ar);
    assign pi_next = PW'(r) * PW'(pipe_reg[S_R].ai);

    assign rd_next = NW'(round_q(wide_t'(pd_reg)));
    assign rr_next = NW'(round_q(wide_t'(pr_reg)));
    assign ri_next = NW'(round_q(wide_t'(pi_reg)));

    assign swap36 = mag(pipe_reg[S_R+2].br) < mag(pipe_reg[S_R+2].bi);
    always_comb
    begin
        if (swap36)
        begin
            den_next = NW'(pipe_reg[S_R+2].bi) + rd_reg;
            nr_next = rr_reg + NW'(pipe_reg[S_R+2].ai);
            ni_next = ri_reg - NW'(pipe_reg[S_R+2].ar);
        end
        else
        begin
            den_next = NW'(pipe_reg[S_R+2].br) + rd_reg;
            nr_next = NW'(pipe_reg[S_R+2].ar) + ri_reg;
            ni_next = NW'(pipe_reg[S_R+2].ai) - rr_reg;
        end
    end

    assign nr_mag = nr_reg[NW-1] ? NW'(-nr_reg) : NW'(nr_reg);
    assign ni_mag = ni_reg[NW-1] ? NW'(-ni_reg) : NW'(ni_reg);
    assign den_mag = den_reg[NW-1] ? NW'(-den_reg) : NW'(den_reg);

    cau_div u_div_re (
        .clk (clk),
        .ce  (ce),
        .num (DIV_NW'({nr_mag, {FRAC_W{1'b0}}})),
        .den (DIV_DW'(den_mag)),
        .quo (div2_quo),
        .ovf (div2_ovf)
    );

    cau_div u_div_im (
        .clk (clk),
        .ce  (ce),
        .num (DIV_NW'({ni_mag, {FRAC_W{1'b0}}})),
        .den (DIV_DW'(den_mag)),
        .quo (div3_quo),
        .ovf (div3_ovf)
    );

    assign dq_re = saturate(to_wide(div2_quo, div2_ovf, pipe_reg[S_DQ].dsre));
    assign dq_im = saturate(to_wide(div3_quo, div3_ovf, pipe_reg[S_DQ].dsim));

    // magnitude and square-root path
    assign xx_next = (2*DATA_W)'(mag(pipe_reg[0].ar)) * (2*DATA_W)'(mag(pipe_reg[0].ar));
    assign yy_next = (2*DATA_W)'(mag(pipe_reg[0].ai)) * (2*DATA_W)'(mag(pipe_reg[0].ai));

    cau_sqrt u_sqrt_mag (
        .clk  (clk),
        .ce   (ce),
        .rad  (SQ_IW'(xx_reg + yy_reg)),
        .root (sq1_root)
    );

    assign sq2_sum = NW'(mag(pipe_reg[S_MG].ar)) + NW'(sq1_root);

    cau_sqrt u_sqrt_w (
        .clk  (clk),
        .ce   (ce),
        .rad  (SQ_IW'(sq2_sum) << (FRAC_W - 1)),
        .root (sq2_root)
    );

    cau_div u_div_sq (
        .clk (clk),
        .ce  (ce),
        .num (DIV_NW'({mag(pipe_reg[S_W].ai), {FRAC_W{1'b0}}})),
        .den (DIV_DW'({sq2_root, 1'b0})),
        .quo (div4_quo),
        .ovf (div4_ovf)
    );

    // product path for multiply and scale
    assign mrr_next = (2*DATA_W)'(pipe_reg[S_MUL].ar) * (2*DATA_W)'(pipe_reg[S_MUL].br);
    assign mii_next = (2*DATA_W)'(pipe_reg[S_MUL].ai) * (2*DATA_W)'(pipe_reg[S_MUL].bi);
    assign mri_next = (2*DATA_W)'(pipe_reg[S_MUL].ar) * (2*DATA_W)'(pipe_reg[S_MUL].bi);
    assign mir_next = (2*DATA_W)'(pipe_reg[S_MUL].ai) * (2*DATA_W)'(pipe_reg[S_MUL].br);

    always_comb
    begin
        if (pipe_reg[S_LAST-1].op == OP_SCALE)
        begin
            mre_next = wide_t'(mrr_reg);
            mim_next = wide_t'(mir_reg);
        end
        else
        begin
            mre_next = wide_t'(mrr_reg) - wide_t'(mii_reg);
            mim_next = wide_t'(mri_reg) + wide_t'(mir_reg);
        end
    end

    // item line, with results dropped in where they appear
    always_comb
    begin
        pipe_next[0] = pipe_reg[0];
        pipe_next[0].op = s_axis_tuser;
        pipe_next[0].ar = s_axis_tdata[DATA_W-1:0];
        pipe_next[0].ai = s_axis_tdata[2*DATA_W-1:DATA_W];
        pipe_next[0].br = s_axis_tdata[3*DATA_W-1:2*DATA_W];
        pipe_next[0].bi = s_axis_tdata[4*DATA_W-1:3*DATA_W];
        for (int t = 1; t <= S_LAST; t++)
        begin
            pipe_next[t] = pipe_reg[t-1];
        end
        pipe_next[S_DEN+1].dsre = nr_reg[NW-1] ^ den_reg[NW-1];
        pipe_next[S_DEN+1].dsim = ni_reg[NW-1] ^ den_reg[NW-1];
        pipe_next[S_DEN+1].dz = (den_reg == '0) ||
                                (pipe_reg[S_DEN].br == '0 && pipe_reg[S_DEN].bi == '0);
        pipe_next[S_DQ+1].dre = dq_re.val;
        pipe_next[S_DQ+1].dim = dq_im.val;
        pipe_next[S_DQ+1].dsat = dq_re.sat | dq_im.sat;
        pipe_next[S_MG+1].mg = sq1_root;
        pipe_next[S_W+1].w = sq2_root;
    end

    // final selection and saturation
    always_comb
    begin
        pipe_t p;
        wide_t re_w;
        wide_t im_w;
        wide_t q4;
        wide_t wv;
        sat_t s_re;
        sat_t s_im;
        logic extra_sat;
        logic divz;
        p = pipe_reg[S_LAST];
        q4 = to_wide(div4_quo, div4_ovf, 1'b0);
        wv = wide_t'(p.w);
        re_w = '0;
        im_w = '0;
        extra_sat = 1'b0;
        divz = 1'b0;
        unique case (p.op)
            OP_ADD:
            begin
                re_w = wide_t'(p.ar) + wide_t'(p.br);
                im_w = wide_t'(p.ai) + wide_t'(p.bi);
            end
            OP_SUB:
            begin
                re_w = wide_t'(p.ar) - wide_t'(p.br);
                im_w = wide_t'(p.ai) - wide_t'(p.bi);
            end
            OP_MUL, OP_SCALE:
            begin
                re_w = round_q(mre_reg);
                im_w = round_q(mim_reg);
            end
            OP_DIV:
            begin
                if (p.dz)
                begin
                    divz = 1'b1;
                end
                else
                begin
                    re_w = wide_t'(p.dre);
                    im_w = wide_t'(p.dim);
                    extra_sat = p.dsat;
                end
            end
            OP_CONJ:
            begin
                re_w = wide_t'(p.ar);
                im_w = -wide_t'(p.ai);
            end
            OP_ABS:
            begin
                re_w = wide_t'(p.mg);
            end
            OP_SQRT:
            begin
                if ((p.ar == '0 && p.ai == '0) || p.w == '0)
                begin
                    re_w = '0;
                end
                else if (!p.ar[DATA_W-1])
                begin
                    re_w = wv;
                    im_w = p.ai[DATA_W-1] ? -q4 : q4;
                end
                else
                begin
                    im_w = p.ai[DATA_W-1] ? -wv : wv;
                    re_w = q4;
                end
            end
        endcase
        s_re = saturate(re_w);
        s_im = saturate(im_w);
        res_re_next = s_re.val;
        res_im_next = s_im.val;
        priority if (divz)
        begin
            status_next = ST_DIVZ;
        end
        else if (s_re.sat || s_im.sat || extra_sat)
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg <= {vld_reg[S_LAST-1:0], s_axis_tvalid};
            out_vld_reg <= vld_reg[S_LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int t = 0; t <= S_LAST; t++)
            begin
                pipe_reg[t] <= pipe_next[t];
            end
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            pd_reg <= pd_next;
            pr_reg <= pr_next;
            pi_reg <= pi_next;
            rd_reg <= rd_next;
            rr_reg <= rr_next;
            ri_reg <= ri_next;
            den_reg <= den_next;
            nr_reg <= nr_next;
            ni_reg <= ni_next;
            mrr_reg <= mrr_next;
            mii_reg <= mii_next;
            mri_reg <= mri_next;
            mir_reg <= mir_next;
            mre_reg <= mre_next;
            mim_reg <= mim_next;
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata = {res_im_reg, res_re_reg};
    assign m_axis_tuser = status_reg;

endmodule

// ===== sim/tb_complex_arithmetic_unit.sv =====
// tb_complex_arithmetic_unit: stream testbench for the complex arithmetic unit, a directed
// table then bursty random requests, each result checked against its table entry or a behavioural predictor.
// Depends on cau_pkg and the complex_arithmetic_unit rtl.
module tb_complex_arithmetic_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    localparam int  N_RANDOM = 880;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 200;
    localparam int  HOLD_CYCLES = 400;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam longint I64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] ar;
        logic signed [DATA_W-1:0] ai;
        logic signed [DATA_W-1:0] br;
        logic signed [DATA_W-1:0] bi;
        logic                     known;
        logic signed [DATA_W-1:0] er;
        logic signed [DATA_W-1:0] ei;
        logic [STAT_W-1:0]        es;
    } cau_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic [STAT_W-1:0]        st;
    } cau_res_t;

    // expected values only where obvious at a glance, the rest go to the predictor
    localparam cau_req_t DIRECTED [19] = '{
        '{OP_ADD, DATA_MAX, 0, DATA_MAX, 0, 1'b1, DATA_MAX, 0, ST_SAT},
        '{OP_ADD, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, 1'b1, DATA_MIN, DATA_MIN, ST_SAT},
        '{OP_SUB, 0, 0, DATA_MIN, 0, 1'b1, DATA_MAX, 0, ST_SAT},
        '{OP_MUL, 2 * ONE, ONE, ONE, -ONE, 1'b0, 0, 0, ST_OK},
        '{OP_MUL, DATA_MIN, DATA_MIN, DATA_MIN, DATA_MIN, 1'b0, 0, 0, ST_OK},
        '{OP_DIV, 5, 7, 0, 0, 1'b1, 0, 0, ST_DIVZ},
        '{OP_DIV, ONE, ONE, ONE, 0, 1'b1, ONE, ONE, ST_OK},
        '{OP_DIV, DATA_MAX, DATA_MIN, 1, -1, 1'b0, 0, 0, ST_OK},
        '{OP_DIV, ONE, 0, 1, 1, 1'b0, 0, 0, ST_OK},
        '{OP_CONJ, 3, DATA_MIN, 0, 0, 1'b1, 3, DATA_MAX, ST_SAT},
        '{OP_CONJ, -5, 7, 0, 0, 1'b1, -5, -7, ST_OK},
        '{OP_ABS, 3 * ONE, 4 * ONE, 0, 0, 1'b1, 5 * ONE, 0, ST_OK},
        '{OP_ABS, DATA_MIN, DATA_MIN, 0, 0, 1'b0, 0, 0, ST_OK},
        '{OP_SQRT, 0, 0, 0, 0, 1'b1, 0, 0, ST_OK},
        '{OP_SQRT, -4 * ONE, 0, 0, 0, 1'b0, 0, 0, ST_OK},
        '{OP_SQRT, -4 * ONE, -ONE, 0, 0, 1'b0, 0, 0, ST_OK},
        '{OP_SQRT, DATA_MAX, DATA_MAX, 0, 0, 1'b0, 0, 0, ST_OK},
        '{OP_SCALE, 3 * ONE, -ONE, 2 * ONE, 0, 1'b1, 6 * ONE, -2 * ONE, ST_OK},
        '{OP_SCALE, DATA_MAX, DATA_MIN, DATA_MIN, 0, 1'b0, 0, 0, ST_OK}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [STAT_W-1:0]      m_axis_tuser;

    cau_req_t cur;
    cau_res_t pending_results[$];
    int       n_errors;
    int       n_taken;
    int       n_returned;
    int       n_cycles;
    int       op_seen[8];
    int       st_seen[4];
    bit       hold_done;

    complex_arithmetic_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // fixed-point helpers of the predictor
    function automatic longint signed_of(bit neg, longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? 64'd0 - longint'(v) : longint'(v);
    endfunction

    function automatic longint round_frac(longint v);
        longint unsigned m;
        m = (abs64(v) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
        return signed_of(v < 0, m);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return round_frac(a * b);
    endfunction

    function automatic longint sum_clamped(longint p, longint q);
        if (p > 0 && q > I64_MAX - p)
            return I64_MAX;
        if (p < 0 && q < I64_MIN - p)
            return I64_MIN;
        return p + q;
    endfunction

    function automatic longint qdiv(longint n, longint d);
        longint unsigned un;
        longint unsigned ud;
        un = abs64(n) << FRAC_W;
        ud = abs64(d);
        return signed_of((n < 0) != (d < 0), (un + ud / 2) / ud);
    endfunction

    function automatic longint unsigned root_rounded(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (v > r)
            r++;
        return r;
    endfunction

    function automatic longint clamp32(longint v, ref bit hit);
        if (v > longint'(DATA_MAX))
        begin
            hit = 1'b1;
            return longint'(DATA_MAX);
        end
        if (v < longint'(DATA_MIN))
        begin
            hit = 1'b1;
            return longint'(DATA_MIN);
        end
        return v;
    endfunction

    function automatic cau_res_t complex_alu_model(cau_req_t q);
        cau_res_t       r;
        longint         ar, ai, br, bi, re, im, k, den, nr, ni;
        longint unsigned x, y, mg, w;
        logic [STAT_W-1:0] st;
        bit             hit;
        ar = longint'(q.ar);
        ai = longint'(q.ai);
        br = longint'(q.br);
        bi = longint'(q.bi);
        re = 0;
        im = 0;
        st = ST_OK;
        hit = 1'b0;
        case (q.op)
            OP_ADD:
            begin
                re = ar + br;
                im = ai + bi;
            end
            OP_SUB:
            begin
                re = ar - br;
                im = ai - bi;
            end
            OP_MUL:
            begin
                re = round_frac(sum_clamped(ar * br, -(ai * bi)));
                im = round_frac(sum_clamped(ar * bi, ai * br));
            end
            OP_DIV:
            begin
                if (br == 0 && bi == 0)
                    st = ST_DIVZ;
                else
                begin
                    if (abs64(br) >= abs64(bi))
                    begin
                        k = qdiv(bi, br);
                        den = br + qmul(k, bi);
                        nr = ar + qmul(k, ai);
                        ni = ai - qmul(k, ar);
                    end
                    else
                    begin
                        k = qdiv(br, bi);
                        den = bi + qmul(k, br);
                        nr = qmul(ar, k) + ai;
                        ni = qmul(ai, k) - ar;
                    end
                    if (den == 0)
                        st = ST_DIVZ;
                    else
                    begin
                        re = qdiv(nr, den);
                        im = qdiv(ni, den);
                    end
                end
            end
            OP_CONJ:
            begin
                re = ar;
                im = -ai;
            end
            OP_ABS:
            begin
                x = abs64(ar);
                y = abs64(ai);
                re = longint'(root_rounded(x * x + y * y));
            end
            OP_SQRT:
            begin
                if (ar != 0 || ai != 0)
                begin
                    x = abs64(ar);
                    y = abs64(ai);
                    mg = root_rounded(x * x + y * y);
                    w = root_rounded((x + mg) << (FRAC_W - 1));
                    if (w != 0)
                    begin
                        if (ar >= 0)
                        begin
                            re = longint'(w);
                            im = qdiv(ai, 2 * longint'(w));
                        end
                        else
                        begin
                            im = ai >= 0 ? longint'(w) : -longint'(w);
                            re = qdiv(ai, 2 * im);
                        end
                    end
                end
            end
            default:
            begin
                re = qmul(br, ar);
                im = qmul(br, ai);
            end
        endcase
        re = clamp32(re, hit);
        im = clamp32(im, hit);
        if (st == ST_OK && hit)
            st = ST_SAT;
        r.re = re[DATA_W-1:0];
        r.im = im[DATA_W-1:0];
        r.st = st;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d (result %0d, t=%0t)",
                 what, got, want, n_returned, $realtime);
    endtask

    // scoreboard: predict on accepted requests, compare on accepted results
    always @(posedge clk)
    begin
        cau_res_t want;
        cau_res_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (cur.known)
                    want = '{re: cur.er, im: cur.ei, st: cur.es};
                else
                    want = complex_alu_model(cur);
                pending_results.push_back(want);
                op_seen[cur.op]++;
                n_taken++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.re = m_axis_tdata[DATA_W-1:0];
                got.im = m_axis_tdata[2*DATA_W-1:DATA_W];
                got.st = m_axis_tuser;
                st_seen[got.st]++;
                if (pending_results.size() == 0)
                begin
                    n_errors++;
                    $display("unexpected result re=%0d im=%0d status=%0d",
                             got.re, got.im, got.st);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.re !== want.re)
                        report("res_re", longint'(got.re), longint'(want.re));
                    if (got.im !== want.im)
                        report("res_im", longint'(got.im), longint'(want.im));
                    if (got.st !== want.st)
                        report("status", longint'(got.st), longint'(want.st));
                end
                n_returned++;
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     n_cycles, pending_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: rotating stall patterns, plus one long hold-off to back the pipe up
    initial
    begin
        int hold_left;
        int phase;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase = (n_cycles / 300) % 4;
            if (!hold_done && n_returned >= 300)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (phase == 0)
                m_axis_tready <= 1'b1;
            else if (phase == 1)
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            else if (phase == 2)
                m_axis_tready <= (n_cycles % 5) != 0;
            else
                m_axis_tready <= ($urandom_range(0, 1) == 1);
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_operand();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6: v = $urandom_range(0, 16 * ONE);
            7:
            begin
                case ($urandom_range(0, 4))
                    0: v = DATA_MAX;
                    1: v = DATA_MIN;
                    2: v = ONE;
                    3: v = -ONE;
                    default: v = 0;
                endcase
            end
            8: v = $urandom_range(0, 7);
            default: v = 0;
        endcase
        if ($urandom_range(0, 1) == 1 && v != DATA_MIN)
            v = -v;
        return v;
    endfunction

    task automatic send_request(cau_req_t q);
        @(negedge clk);
        cur = q;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= q.op;
        s_axis_tdata <= {q.bi, q.br, q.ai, q.ar};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic idle_gap(int n);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    initial
    begin
        cau_req_t q;
        int burst;
        n_errors = 0;
        n_taken = 0;
        n_returned = 0;
        n_cycles = 0;
        cur = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_ADD;
        rst_n = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED[i])
        begin
            send_request(DIRECTED[i]);
            if (i % 4 == 3)
                idle_gap($urandom_range(1, 3));
        end

        burst = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
            begin
                idle_gap(1);
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            q = '0;
            q.op = OP_W'($urandom_range(0, 7));
            q.ar = pick_operand();
            q.ai = pick_operand();
            q.br = pick_operand();
            q.bi = pick_operand();
            if (q.op == OP_DIV && $urandom_range(0, 19) == 0)
            begin
                q.br = 0;
                q.bi = 0;
            end
            send_request(q);
            if (burst == 0)
            begin
                // stretches of back-to-back requests between gapped ones
                burst = (n / 150) % 2 == 0 ? $urandom_range(1, 20) : 60;
                if ((n / 150) % 2 == 0)
                    idle_gap($urandom_range(1, 8));
            end
            else
                burst--;
        end
        idle_gap(1);

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("covered %0d requests, %0d results; per op add..scale: %0d %0d %0d %0d %0d %0d %0d %0d",
                 n_taken, n_returned, op_seen[0], op_seen[1], op_seen[2], op_seen[3],
                 op_seen[4], op_seen[5], op_seen[6], op_seen[7]);
        $display("status ok/div-zero/saturated: %0d/%0d/%0d, long output stall %0s",
                 st_seen[0], st_seen[1], st_seen[2], hold_done ? "seen" : "missed");
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
